// ===== hdl/pes_pkg.sv =====
// ----------------------------------------------------------------------------
// pes_pkg
// Shared types and constants of the PUCT edge select unit.
// ----------------------------------------------------------------------------
package pes_pkg;

    localparam int MAX_EDGES_DEF = 64;

    localparam int IDX_W   = 6;
    localparam int PRIOR_W = 16;
    localparam int VIS_W   = 16;
    localparam int VAL_W   = 32;
    localparam int MCNT_W  = 8;
    localparam int ACT_W   = 16;
    localparam int GAIN_W  = 24;

    localparam int S_TDATA_W = 168;
    localparam int M_TDATA_W = 56;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;

    // divider: 40-bit dividend, 17-bit divisor (1 + visits, or visits for the mean value)
    localparam int DIV_N_W = 40;
    localparam int DIV_D_W = 17;

    // sqrt of (N << 32): 48-bit radicand, 24-bit root
    localparam int SQ_X_W     = 48;
    localparam int SQ_ROOT_W  = 24;
    localparam int SQ_REM_W   = 26;
    localparam int SQ_STEPS   = 24;

    localparam int MUL_A_W = 25;
    localparam int MUL_B_W = 33;
    localparam int MUL_P_W = 58;

    localparam logic signed [VAL_W-1:0] PRUNED_SCORE = -32'sd655353446;
    localparam logic signed [VAL_W-1:0] SCORE_MIN    = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] SCORE_MAX    = 32'sh7FFF_FFFF;

    typedef enum logic [2:0] {
        REG_EXPLORE_GAIN   = 3'd0,
        REG_HEURISTIC_GAIN = 3'd1,
        REG_VALUE_FROM_MAX = 3'd2,
        REG_HEUR_FROM_CNT  = 3'd3,
        REG_PRIOR_ONLY     = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== hdl/pes_div.sv =====
// ----------------------------------------------------------------------------
// pes_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pes_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  pes_pkg::div_req_t req,
    output pes_pkg::div_rsp_t rsp
);
    import pes_pkg::*;

    localparam int CNT_W = $clog2(DIV_N_W);

    logic [DIV_N_W-1:0] quo_reg, quo_next;
    logic [DIV_D_W-1:0] rem_reg, rem_next;
    logic [DIV_D_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [DIV_D_W:0]   trial;
    logic               last_step;

    assign trial     = {rem_reg, quo_reg[DIV_N_W-1]};
    assign last_step = (cnt_reg == CNT_W'(DIV_N_W-1));

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = DIV_D_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[DIV_N_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DIV_D_W-1:0];
                quo_next = {quo_reg[DIV_N_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (last_step) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== hdl/puct_edge_select_unit.sv =====
// ----------------------------------------------------------------------------
// puct_edge_select_unit
// PUCT edge selection over the edges of one search-tree node.
// ----------------------------------------------------------------------------
// One beat per edge; the beat with tlast emits the best edge of the node.
// An edge is scored by a sequencer around one multiplier and one shared
// bit-serial divider: a 24-step square root, then up to three divisions
// (exploration, mean value, heuristic); the mean and heuristic divisions
// can be skipped, and a pruned, prior-only or overflow edge skips the
// scoring altogether. s_tready is low while an edge is being scored.
module puct_edge_select_unit #(
    parameter int MAX_EDGES = pes_pkg::MAX_EDGES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // edge_prior, edge_visits, parent_visits, edge_total, edge_best,
    // misaligned_count, misalign_val, action_code
    input  logic [pes_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           s_tuser,   // edge_pruned
    input  logic                           s_tlast,   // last_edge
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // best_index, best_action, best_score, overflow, zero pad
    output logic [pes_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pes_pkg::APB_AW-1:0]     paddr,
    input  logic [pes_pkg::APB_DW-1:0]     pwdata,
    output logic [pes_pkg::APB_DW-1:0]     prdata,
    output logic                           pready
);
    import pes_pkg::*;

    localparam int CNT_W   = $clog2(MAX_EDGES + 1);
    localparam int STEP_W  = $clog2(SQ_STEPS);
    localparam int SUM_W   = 43;

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_SQRT   = 13'b0000000000010,
        ST_MUL_T  = 13'b0000000000100,
        ST_MUL_TS = 13'b0000000001000,
        ST_U_GO   = 13'b0000000010000,
        ST_U_WAIT = 13'b0000000100000,
        ST_Q_GO   = 13'b0000001000000,
        ST_Q_WAIT = 13'b0000010000000,
        ST_H_MUL  = 13'b0000100000000,
        ST_H_GO   = 13'b0001000000000,
        ST_H_WAIT = 13'b0010000000000,
        ST_SUM    = 13'b0100000000000,
        ST_FINISH = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [GAIN_W-1:0] gain_e_reg, gain_e_next;
    logic [GAIN_W-1:0] gain_h_reg, gain_h_next;
    logic              vmax_reg, vmax_next;
    logic              hcnt_reg, hcnt_next;
    logic              ponly_reg, ponly_next;

    // latched edge
    logic [PRIOR_W-1:0]       prior_reg;
    logic [VIS_W-1:0]         n_reg;
    logic signed [VAL_W-1:0]  total_reg;
    logic signed [VAL_W-1:0]  best_reg;
    logic [MCNT_W-1:0]        mcount_reg;
    logic signed [VAL_W-1:0]  mscore_reg;
    logic [ACT_W-1:0]         action_reg;
    logic                     last_reg;

    // datapath
    logic [SQ_X_W-1:0]        sq_x_reg, sq_x_next;
    logic [SQ_REM_W-1:0]      sq_rem_reg, sq_rem_next;
    logic [SQ_ROOT_W-1:0]     sq_root_reg, sq_root_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic signed [MUL_P_W-1:0] prod_reg, prod_next;
    logic [VAL_W-1:0]         u_reg, u_next;
    logic signed [VAL_W:0]    q_reg, q_next;
    logic signed [DIV_N_W:0]  h_reg, h_next;
    logic signed [VAL_W-1:0]  sc_reg, sc_next;

    // running best
    logic signed [VAL_W-1:0]  rb_score_reg, rb_score_next;
    logic [IDX_W-1:0]         rb_index_reg, rb_index_next;
    logic [ACT_W-1:0]         rb_action_reg, rb_action_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     ovf_reg, ovf_next;
    logic                     upd_reg, upd_next;

    // output
    logic                     m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]         o_index_reg, o_index_next;
    logic [ACT_W-1:0]         o_action_reg, o_action_next;
    logic signed [VAL_W-1:0]  o_score_reg, o_score_next;
    logic                     o_ovf_reg, o_ovf_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    pes_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    logic                       in_beat;
    logic                       cfg_wr;
    logic [2:0]                 cfg_idx;
    logic [SQ_REM_W+1:0]        sq_rem_sh;
    logic [SQ_REM_W+1:0]        sq_trial;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [MUL_P_W-1:0]  mul_p;
    logic [VAL_W-1:0]           total_mag;
    logic [MUL_P_W-1:0]         prod_mag;
    logic [DIV_D_W-1:0]         n_plus1;
    logic signed [DIV_N_W:0]    hq_mag;
    logic signed [VAL_W:0]      qq_mag;
    logic signed [SUM_W-1:0]    sum;
    logic [CNT_W+IDX_W-1:0]     cnt_ext;

    assign in_beat = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    assign sq_rem_sh = {sq_rem_reg, sq_x_reg[SQ_X_W-1 -: 2]};
    assign sq_trial  = {2'b00, sq_root_reg, 2'b01};

    assign mul_p     = MUL_P_W'(mul_a * mul_b);
    assign total_mag = total_reg[VAL_W-1] ? VAL_W'(-total_reg) : VAL_W'(total_reg);
    assign prod_mag  = prod_reg[MUL_P_W-1] ? MUL_P_W'(-prod_reg) : MUL_P_W'(prod_reg);
    assign n_plus1   = {1'b0, n_reg} + 1'b1;
    assign hq_mag    = $signed({1'b0, div_rsp.quotient});
    assign qq_mag    = $signed({1'b0, div_rsp.quotient[VAL_W-1:0]});
    assign sum       = SUM_W'(q_reg) + $signed({11'b0, u_reg}) + SUM_W'(h_reg);
    assign cnt_ext   = {{IDX_W{1'b0}}, cnt_reg};

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MUL_T: begin
                mul_a = $signed({1'b0, gain_e_reg});
                mul_b = $signed({17'b0, prior_reg});
            end
            ST_MUL_TS: begin
                mul_a = $signed({1'b0, prod_reg[39:16]});
                mul_b = $signed({9'b0, sq_root_reg});
            end
            ST_H_MUL: begin
                mul_a = $signed({1'b0, gain_h_reg});
                mul_b = hcnt_reg ? $signed({25'b0, mcount_reg}) : MUL_B_W'(mscore_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            REG_EXPLORE_GAIN:   prdata = {8'b0, gain_e_reg};
            REG_HEURISTIC_GAIN: prdata = {8'b0, gain_h_reg};
            REG_VALUE_FROM_MAX: prdata = {31'b0, vmax_reg};
            REG_HEUR_FROM_CNT:  prdata = {31'b0, hcnt_reg};
            REG_PRIOR_ONLY:     prdata = {31'b0, ponly_reg};
            default:            prdata = '0;
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        gain_e_next    = gain_e_reg;
        gain_h_next    = gain_h_reg;
        vmax_next      = vmax_reg;
        hcnt_next      = hcnt_reg;
        ponly_next     = ponly_reg;
        sq_x_next      = sq_x_reg;
        sq_rem_next    = sq_rem_reg;
        sq_root_next   = sq_root_reg;
        step_next      = step_reg;
        prod_next      = prod_reg;
        u_next         = u_reg;
        q_next         = q_reg;
        h_next         = h_reg;
        sc_next        = sc_reg;
        rb_score_next  = rb_score_reg;
        rb_index_next  = rb_index_reg;
        rb_action_next = rb_action_reg;
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        upd_next       = upd_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        o_index_next   = o_index_reg;
        o_action_next  = o_action_reg;
        o_score_next   = o_score_reg;
        o_ovf_next     = o_ovf_reg;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = n_plus1;

        if (cfg_wr) begin
            unique case (cfg_idx)
                REG_EXPLORE_GAIN:   gain_e_next = pwdata[GAIN_W-1:0];
                REG_HEURISTIC_GAIN: gain_h_next = pwdata[GAIN_W-1:0];
                REG_VALUE_FROM_MAX: vmax_next   = pwdata[0];
                REG_HEUR_FROM_CNT:  hcnt_next   = pwdata[0];
                REG_PRIOR_ONLY:     ponly_next  = pwdata[0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    upd_next = 1'b0;
                    if (cnt_reg >= CNT_W'(MAX_EDGES)) begin
                        ovf_next   = 1'b1;
                        state_next = ST_FINISH;
                    end else if (ponly_reg) begin
                        sc_next    = $signed({16'b0, s_tdata[15:0]});
                        upd_next   = 1'b1;
                        state_next = ST_FINISH;
                    end else if (s_tuser) begin
                        sc_next    = PRUNED_SCORE;
                        upd_next   = 1'b1;
                        state_next = ST_FINISH;
                    end else begin
                        sq_x_next    = {s_tdata[47:32], 32'b0};
                        sq_rem_next  = '0;
                        sq_root_next = '0;
                        step_next    = '0;
                        state_next   = ST_SQRT;
                    end
                end
            end
            ST_SQRT: begin
                if (sq_rem_sh >= sq_trial) begin
                    sq_rem_next  = SQ_REM_W'(sq_rem_sh - sq_trial);
                    sq_root_next = {sq_root_reg[SQ_ROOT_W-2:0], 1'b1};
                end else begin
                    sq_rem_next  = sq_rem_sh[SQ_REM_W-1:0];
                    sq_root_next = {sq_root_reg[SQ_ROOT_W-2:0], 1'b0};
                end
                sq_x_next = {sq_x_reg[SQ_X_W-3:0], 2'b00};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(SQ_STEPS-1)) begin
                    state_next = ST_MUL_T;
                end
            end
            ST_MUL_T: begin
                prod_next  = mul_p;
                state_next = ST_MUL_TS;
            end
            ST_MUL_TS: begin
                prod_next  = mul_p;
                state_next = ST_U_GO;
            end
            ST_U_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = {8'b0, prod_reg[47:16]};
                state_next       = ST_U_WAIT;
            end
            ST_U_WAIT: begin
                if (div_rsp.done) begin
                    u_next     = div_rsp.quotient[VAL_W-1:0];
                    state_next = ST_Q_GO;
                end
            end
            ST_Q_GO: begin
                if (n_reg == '0) begin
                    q_next     = '0;
                    state_next = ST_H_MUL;
                end else if (vmax_reg) begin
                    q_next     = (VAL_W+1)'(best_reg);
                    state_next = ST_H_MUL;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {8'b0, total_mag};
                    div_req.divisor  = {1'b0, n_reg};
                    state_next       = ST_Q_WAIT;
                end
            end
            ST_Q_WAIT: begin
                if (div_rsp.done) begin
                    q_next     = total_reg[VAL_W-1] ? -qq_mag : qq_mag;
                    state_next = ST_H_MUL;
                end
            end
            ST_H_MUL: begin
                if (gain_h_reg == '0) begin
                    h_next     = '0;
                    state_next = ST_SUM;
                end else begin
                    prod_next  = mul_p;
                    state_next = ST_H_GO;
                end
            end
            ST_H_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = hcnt_reg ? prod_reg[DIV_N_W-1:0] : prod_mag[55:16];
                state_next       = ST_H_WAIT;
            end
            ST_H_WAIT: begin
                if (div_rsp.done) begin
                    h_next     = prod_reg[MUL_P_W-1] ? -hq_mag : hq_mag;
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                if (sum > SUM_W'(SCORE_MAX)) begin
                    sc_next = SCORE_MAX;
                end else if (sum < SUM_W'(SCORE_MIN)) begin
                    sc_next = SCORE_MIN;
                end else begin
                    sc_next = sum[VAL_W-1:0];
                end
                upd_next   = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (upd_reg) begin
                    if (cnt_reg == '0 || sc_reg > rb_score_reg) begin
                        rb_score_next  = sc_reg;
                        rb_index_next  = cnt_ext[IDX_W-1:0];
                        rb_action_next = action_reg;
                    end
                    cnt_next = cnt_reg + 1'b1;
                    upd_next = 1'b0;
                end
                if (!upd_reg) begin
                    if (!last_reg) begin
                        state_next = ST_IDLE;
                    end else if (!m_valid_reg || m_tready) begin
                        m_valid_next   = 1'b1;
                        o_index_next   = rb_index_reg;
                        o_action_next  = rb_action_reg;
                        o_score_next   = rb_score_reg;
                        o_ovf_next     = ovf_reg;
                        rb_score_next  = SCORE_MIN;
                        rb_index_next  = '0;
                        rb_action_next = '0;
                        cnt_next       = '0;
                        ovf_next       = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            gain_e_reg    <= GAIN_W'(65536);
            gain_h_reg    <= '0;
            vmax_reg      <= 1'b0;
            hcnt_reg      <= 1'b0;
            ponly_reg     <= 1'b0;
            rb_score_reg  <= SCORE_MIN;
            rb_index_reg  <= '0;
            rb_action_reg <= '0;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            upd_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            gain_e_reg    <= gain_e_next;
            gain_h_reg    <= gain_h_next;
            vmax_reg      <= vmax_next;
            hcnt_reg      <= hcnt_next;
            ponly_reg     <= ponly_next;
            rb_score_reg  <= rb_score_next;
            rb_index_reg  <= rb_index_next;
            rb_action_reg <= rb_action_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            upd_reg       <= upd_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_beat) begin
            prior_reg  <= s_tdata[15:0];
            n_reg      <= s_tdata[31:16];
            total_reg  <= s_tdata[79:48];
            best_reg   <= s_tdata[111:80];
            mcount_reg <= s_tdata[119:112];
            mscore_reg <= s_tdata[151:120];
            action_reg <= s_tdata[167:152];
            last_reg   <= s_tlast;
        end
        sq_x_reg     <= sq_x_next;
        sq_rem_reg   <= sq_rem_next;
        sq_root_reg  <= sq_root_next;
        step_reg     <= step_next;
        prod_reg     <= prod_next;
        u_reg        <= u_next;
        q_reg        <= q_next;
        h_reg        <= h_next;
        sc_reg       <= sc_next;
        o_index_reg  <= o_index_next;
        o_action_reg <= o_action_next;
        o_score_reg  <= o_score_next;
        o_ovf_reg    <= o_ovf_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, o_ovf_reg, o_score_reg, o_action_reg, o_index_reg};

endmodule
